### rtl/wd_pkg.sv
// wd_pkg: shared constants, codes and types of the waveform decimator
// no dependencies; used by every module in rtl/

package wd_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int SAMPLE_W        = 8;
  localparam int MODE_W          = 2;

  // decimation modes, unused code behaves as plain
  localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PEAK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HALF  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // configuration register indexes
  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'hff;

  // per-group control word handed from front to back
  typedef struct packed {
    logic                half;        // values still need the two half averages
    logic                record_end;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
  } job_ctrl_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIVA,
    B_DIVB,
    B_EMIT
  } back_state_t;

endpackage

### rtl/waveform_decimator.sv
// waveform_decimator: peak-detect / subsample / half-average decimation of 8-bit samples
// results: plain, peak and length-1 groups pass the queue, then the output register;
//   half-average groups also take two 9-step divider passes, with no new pop meanwhile
// throughput: one sample per cycle in, unless a closing sample meets a full queue;
//   other groups pop one per cycle when out is free; a 4-entry queue absorbs bursts
// reset: synchronous active-low rst_n clears group state, queue, divider and output valid;
//   mode resets to plain and group length to 1
// depends on wd_pkg, wd_front, wd_fifo, wd_div, wd_back

module waveform_decimator #(
  parameter int LENGTH_BITS = wd_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic                   cfg_addr,
  input  logic [LENGTH_BITS-1:0] cfg_wdata,
  // sample stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,    // [7:0] sample
  input  logic                   in_tlast,    // end of record
  // decimated pair stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [15:0]            out_tdata,   // [7:0] low_value, [15:8] high_value
  output logic                   out_tlast    // group closed at record end
);

  localparam int SW = LENGTH_BITS + 7;
  localparam int CW = $bits(wd_pkg::job_ctrl_t);
  localparam int JW = CW + 2 * SW + LENGTH_BITS;

  // configuration registers
  logic [wd_pkg::MODE_W-1:0] mode_r;
  logic [LENGTH_BITS-1:0]    glen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= wd_pkg::MODE_PLAIN;
      glen_r <= LENGTH_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        wd_pkg::CFG_MODE:   mode_r <= cfg_wdata[wd_pkg::MODE_W-1:0];
        wd_pkg::CFG_LENGTH: glen_r <= cfg_wdata;
        default:            mode_r <= mode_r;
      endcase
    end
  end

  // front to queue
  logic                   push, q_full;
  wd_pkg::job_ctrl_t      f_ctrl;
  logic [SW-1:0]          f_sum1, f_sum2;
  logic [LENGTH_BITS-1:0] f_len;

  // queue to back
  logic                   q_valid, pop;
  logic [JW-1:0]          q_wdata, q_rdata;
  wd_pkg::job_ctrl_t      b_ctrl;
  logic [SW-1:0]          b_sum1, b_sum2;
  logic [LENGTH_BITS-1:0] b_len;

  logic [7:0]             res_low, res_high;

  wd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .mode         (mode_r),
    .group_length (glen_r),
    .in_valid     (in_tvalid),
    .in_sample    (in_tdata),
    .in_last      (in_tlast),
    .in_ready     (in_tready),
    .q_full       (q_full),
    .push         (push),
    .job_ctrl     (f_ctrl),
    .job_sum1     (f_sum1),
    .job_sum2     (f_sum2),
    .job_len      (f_len)
  );

  // one queue word per closed group
  assign q_wdata = {f_len, f_sum2, f_sum1, f_ctrl};

  wd_fifo #(
    .WIDTH (JW),
    .DEPTH (wd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (q_wdata),
    .full     (q_full),
    .rd_en    (pop),
    .rd_data  (q_rdata),
    .rd_valid (q_valid)
  );

  assign {b_len, b_sum2, b_sum1, b_ctrl} = q_rdata;

  wd_back #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ctrl    (b_ctrl),
    .q_sum1    (b_sum1),
    .q_sum2    (b_sum2),
    .q_len     (b_len),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_low   (res_low),
    .out_high  (res_high),
    .out_last  (out_tlast)
  );

  assign out_tdata = {res_high, res_low};

endmodule

### rtl/wd_front.sv
// wd_front: sample intake, group counting, min/max/first tracking and half sums
// depends on wd_pkg

module wd_front #(
  parameter int LENGTH_BITS = wd_pkg::LENGTH_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [wd_pkg::MODE_W-1:0]           mode,
  input  logic [LENGTH_BITS-1:0]              group_length,
  input  logic                                in_valid,
  input  logic [wd_pkg::SAMPLE_W-1:0]         in_sample,
  input  logic                                in_last,
  output logic                                in_ready,
  input  logic                                q_full,
  output logic                                push,
  output wd_pkg::job_ctrl_t                   job_ctrl,
  output logic [LENGTH_BITS+6:0]              job_sum1,
  output logic [LENGTH_BITS+6:0]              job_sum2,
  output logic [LENGTH_BITS-1:0]              job_len
);

  localparam int SW = LENGTH_BITS + 7;

  logic [LENGTH_BITS-1:0]        pos_r, pos_nxt;
  logic [wd_pkg::SAMPLE_W-1:0]   first_r, first_nxt;
  logic [wd_pkg::SAMPLE_W-1:0]   min_r, min_nxt;
  logic [wd_pkg::SAMPLE_W-1:0]   max_r, max_nxt;
  logic [SW-1:0]                 sum1_r, sum1_nxt;
  logic [SW-1:0]                 sum2_r, sum2_nxt;

  logic [LENGTH_BITS-1:0]        len_eff, half1;
  logic [LENGTH_BITS:0]          pos_inc;
  logic                          closing, accept, in_first;
  logic [wd_pkg::SAMPLE_W-1:0]   first_upd, min_upd, max_upd;
  logic [SW-1:0]                 sum1_upd, sum2_upd;

  assign len_eff  = (group_length == '0) ? LENGTH_BITS'(1) : group_length;
  assign half1    = len_eff >> 1;
  assign pos_inc  = {1'b0, pos_r} + (LENGTH_BITS+1)'(1);
  assign closing  = pos_inc >= {1'b0, len_eff};
  // only a closing sample needs a queue slot
  assign in_ready = !(closing && q_full);
  assign accept   = in_valid && in_ready;

  assign first_upd = (pos_r == '0) ? in_sample : first_r;
  assign min_upd   = (in_sample < min_r) ? in_sample : min_r;
  assign max_upd   = (in_sample > max_r) ? in_sample : max_r;
  assign in_first  = pos_r < half1;
  assign sum1_upd  = in_first ? sum1_r + SW'(in_sample) : sum1_r;
  assign sum2_upd  = in_first ? sum2_r : sum2_r + SW'(in_sample);

  always_comb begin
    job_ctrl.half       = 1'b0;
    job_ctrl.record_end = in_last;
    job_ctrl.lo         = first_upd;
    job_ctrl.hi         = first_upd;
    if (len_eff < LENGTH_BITS'(2)) begin
      job_ctrl.lo = in_sample;
      job_ctrl.hi = in_sample;
    end else begin
      case (mode)
        wd_pkg::MODE_PEAK: begin
          job_ctrl.lo = min_upd;
          job_ctrl.hi = max_upd;
        end
        wd_pkg::MODE_HALF: begin
          job_ctrl.half = 1'b1;
        end
        default: begin
          job_ctrl.lo = first_upd;
          job_ctrl.hi = first_upd;
        end
      endcase
    end
  end

  assign push     = accept && closing;
  assign job_sum1 = sum1_upd;
  assign job_sum2 = sum2_upd;
  assign job_len  = len_eff;

  always_comb begin
    pos_nxt   = pos_r;
    first_nxt = first_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    sum1_nxt  = sum1_r;
    sum2_nxt  = sum2_r;
    if (accept) begin
      if (closing || in_last) begin
        pos_nxt   = '0;
        first_nxt = '0;
        min_nxt   = wd_pkg::SAMPLE_MAX;
        max_nxt   = '0;
        sum1_nxt  = '0;
        sum2_nxt  = '0;
      end else begin
        pos_nxt   = pos_inc[LENGTH_BITS-1:0];
        first_nxt = first_upd;
        min_nxt   = min_upd;
        max_nxt   = max_upd;
        sum1_nxt  = sum1_upd;
        sum2_nxt  = sum2_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      first_r <= '0;
      min_r   <= wd_pkg::SAMPLE_MAX;
      max_r   <= '0;
      sum1_r  <= '0;
      sum2_r  <= '0;
    end else begin
      pos_r   <= pos_nxt;
      first_r <= first_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      sum1_r  <= sum1_nxt;
      sum2_r  <= sum2_nxt;
    end
  end

endmodule

### rtl/wd_fifo.sv
// wd_fifo: small register queue between front and back
// depends on wd_pkg for the default depth

module wd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = wd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             rd_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full     = cnt_r == (AW+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_data  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == AW'(DEPTH-1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == AW'(DEPTH-1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

### rtl/wd_div.sv
// wd_div: restoring divider for a half mean, quotient saturated at 255
// depends on wd_pkg

module wd_div #(
  parameter int LENGTH_BITS = wd_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [LENGTH_BITS+6:0]      dividend,
  input  logic [LENGTH_BITS-1:0]      divisor,
  output logic                        done,
  output logic [wd_pkg::SAMPLE_W-1:0] quotient
);

  // nine steps: the first one only detects a quotient above 255
  localparam int STEPS = wd_pkg::SAMPLE_W + 1;
  localparam int RW    = LENGTH_BITS + wd_pkg::SAMPLE_W;
  localparam int CW    = $clog2(STEPS + 1);

  logic [RW-1:0]    rem_r, rem_nxt;
  logic [RW-1:0]    dsh_r, dsh_nxt;
  logic [STEPS-1:0] q_r, q_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic             ge;

  assign ge       = rem_r >= dsh_r;
  assign done     = done_r;
  assign quotient = q_r[STEPS-1] ? wd_pkg::SAMPLE_MAX : q_r[wd_pkg::SAMPLE_W-1:0];

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = RW'(dividend);
      dsh_nxt = {divisor, {wd_pkg::SAMPLE_W{1'b0}}};
      q_nxt   = '0;
      cnt_nxt = CW'(STEPS);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? rem_r - dsh_r : rem_r;
      dsh_nxt  = dsh_r >> 1;
      q_nxt    = {q_r[STEPS-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = cnt_r == CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

endmodule

### rtl/wd_back.sv
// wd_back: pops finished groups, runs the half averages, drives the result register
// depends on wd_pkg and wd_div

module wd_back #(
  parameter int LENGTH_BITS = wd_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  wd_pkg::job_ctrl_t           q_ctrl,
  input  logic [LENGTH_BITS+6:0]      q_sum1,
  input  logic [LENGTH_BITS+6:0]      q_sum2,
  input  logic [LENGTH_BITS-1:0]      q_len,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wd_pkg::SAMPLE_W-1:0] out_low,
  output logic [wd_pkg::SAMPLE_W-1:0] out_high,
  output logic                        out_last
);

  localparam int SW = LENGTH_BITS + 7;

  wd_pkg::back_state_t state_r, state_nxt;

  logic                        ovalid_r, ovalid_nxt;
  logic [wd_pkg::SAMPLE_W-1:0] olow_r, ohigh_r, qa_r;
  logic                        olast_r, rec_r;
  logic [SW-1:0]               sum2_r;
  logic [LENGTH_BITS-1:0]      half2_r;

  logic                        out_free;
  logic                        div_start, div_done;
  logic [SW-1:0]               div_sum;
  logic [LENGTH_BITS-1:0]      div_den;
  logic [wd_pkg::SAMPLE_W-1:0] div_q;
  logic [LENGTH_BITS-1:0]      head_half1;
  logic                        load_direct, load_half, take_qa;
  logic [wd_pkg::SAMPLE_W-1:0] avg_lo, avg_hi;

  assign out_free   = !ovalid_r || out_ready;
  assign head_half1 = q_len >> 1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wd_pkg::B_IDLE: begin
        if (q_valid && q_ctrl.half) begin
          state_nxt = wd_pkg::B_DIVA;
        end
      end
      wd_pkg::B_DIVA: begin
        if (div_done) begin
          state_nxt = wd_pkg::B_DIVB;
        end
      end
      wd_pkg::B_DIVB: begin
        if (div_done) begin
          state_nxt = wd_pkg::B_EMIT;
        end
      end
      wd_pkg::B_EMIT: begin
        if (out_free) begin
          state_nxt = wd_pkg::B_IDLE;
        end
      end
      default: state_nxt = wd_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    div_start   = 1'b0;
    div_sum     = q_sum1;
    div_den     = head_half1;
    load_direct = 1'b0;
    load_half   = 1'b0;
    take_qa     = 1'b0;
    case (state_r)
      wd_pkg::B_IDLE: begin
        if (q_valid && q_ctrl.half) begin
          pop       = 1'b1;
          div_start = 1'b1;
        end else if (q_valid && out_free) begin
          pop         = 1'b1;
          load_direct = 1'b1;
        end
      end
      wd_pkg::B_DIVA: begin
        div_sum = sum2_r;
        div_den = half2_r;
        if (div_done) begin
          div_start = 1'b1;
          take_qa   = 1'b1;
        end
      end
      wd_pkg::B_EMIT: begin
        load_half = out_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  wd_div #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_sum),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // second quotient sits in the divider until the result is loaded
  assign avg_lo = (qa_r < div_q) ? qa_r : div_q;
  assign avg_hi = (qa_r < div_q) ? div_q : qa_r;

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (load_direct || load_half) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= wd_pkg::B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sum2_r  <= q_sum2;
      half2_r <= q_len - head_half1;
      rec_r   <= q_ctrl.record_end;
    end
    if (take_qa) begin
      qa_r <= div_q;
    end
    if (load_direct) begin
      olow_r  <= q_ctrl.lo;
      ohigh_r <= q_ctrl.hi;
      olast_r <= q_ctrl.record_end;
    end else if (load_half) begin
      olow_r  <= avg_lo;
      ohigh_r <= avg_hi;
      olast_r <= rec_r;
    end
  end

  assign out_valid = ovalid_r;
  assign out_low   = olow_r;
  assign out_high  = ohigh_r;
  assign out_last  = olast_r;

endmodule

### sim/decimator_checker.sv
`timescale 1ns / 100ps
// decimator_checker: watches the config port and both streams of waveform_decimator,
// predicts every decimated pair and compares each output transfer against it
// depends on wd_pkg for register indexes, mode codes and widths

module decimator_checker
  import wd_pkg::*;
#(
  parameter int LEN_W = LENGTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [7:0]       in_tdata,    // [7:0] sample
  input  logic             in_tlast,    // end of record
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [15:0]      out_tdata,   // [7:0] low_value, [15:8] high_value
  input  logic             out_tlast,   // group closed at record end
  output int               mismatches,
  output int               pairs_pending,
  output int               pairs_checked
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic                rec_end;
  } pair_t;

  pair_t expected_pairs[$];
  pair_t head_pair;

  logic [MODE_W-1:0]   dec_mode;
  logic [LEN_W-1:0]    grp_len;
  logic [LEN_W-1:0]    grp_pos;
  logic [SAMPLE_W-1:0] first_smp;
  logic [SAMPLE_W-1:0] run_min;
  logic [SAMPLE_W-1:0] run_max;
  logic [LEN_W+6:0]    sum_first;
  logic [LEN_W+6:0]    sum_second;
  int                  err_count = 0;
  int                  checked   = 0;

  task automatic restart_group();
    grp_pos    = '0;
    first_smp  = '0;
    run_min    = SAMPLE_MAX;
    run_max    = '0;
    sum_first  = '0;
    sum_second = '0;
  endtask

  // floored mean, saturating when a shrunk group overfills a half
  function automatic logic [SAMPLE_W-1:0] half_mean(input logic [LEN_W+6:0] sum,
                                                   input logic [LEN_W:0]   cnt);
    logic [LEN_W+6:0] q;
    if (cnt == 0) return '0;
    q = sum / cnt;
    return (q > SAMPLE_MAX) ? SAMPLE_MAX : q[SAMPLE_W-1:0];
  endfunction

  task automatic fold_sample(input logic [SAMPLE_W-1:0] s, input logic eor);
    logic [LEN_W:0]      eff;
    logic [LEN_W:0]      h1;
    logic [LEN_W:0]      h2;
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    pair_t               p;
    eff = (grp_len == '0) ? (LEN_W+1)'(1) : {1'b0, grp_len};
    h1  = eff >> 1;
    h2  = eff - h1;
    if (grp_pos == 0) first_smp = s;
    if (s < run_min) run_min = s;
    if (s > run_max) run_max = s;
    if ({1'b0, grp_pos} < h1) sum_first = sum_first + s;
    else sum_second = sum_second + s;
    if ({1'b0, grp_pos} + (LEN_W+1)'(1) < eff) begin
      if (eor) restart_group();
      else grp_pos = grp_pos + 1'b1;
    end else begin
      if (eff < 2) begin
        p.lo = s;
        p.hi = s;
      end else if (dec_mode == MODE_PEAK) begin
        p.lo = run_min;
        p.hi = run_max;
      end else if (dec_mode == MODE_HALF) begin
        a = half_mean(sum_first, h1);
        b = half_mean(sum_second, h2);
        p.lo = (a < b) ? a : b;
        p.hi = (a < b) ? b : a;
      end else begin
        p.lo = first_smp;
        p.hi = first_smp;
      end
      p.rec_end = eor;
      expected_pairs.push_back(p);
      restart_group();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dec_mode = MODE_PLAIN;
      grp_len  = LEN_W'(1);
      restart_group();
      expected_pairs.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_MODE) dec_mode = cfg_wdata[MODE_W-1:0];
        else grp_len = cfg_wdata;
      end
      if (in_tvalid && in_tready) fold_sample(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_pairs.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: unexpected pair lo=%h hi=%h last=%b", $realtime,
                     out_tdata[7:0], out_tdata[15:8], out_tlast);
        end else begin
          head_pair = expected_pairs.pop_front();
          checked++;
          if (out_tdata[7:0] !== head_pair.lo || out_tdata[15:8] !== head_pair.hi ||
              out_tlast !== head_pair.rec_end) begin
            err_count++;
            if (err_count <= 10)
              $display("%0t: pair mismatch, expected lo=%h hi=%h last=%b, got lo=%h hi=%h last=%b",
                       $realtime, head_pair.lo, head_pair.hi, head_pair.rec_end,
                       out_tdata[7:0], out_tdata[15:8], out_tlast);
          end
        end
      end
    end
    mismatches    = err_count;
    pairs_pending = expected_pairs.size();
    pairs_checked = checked;
  end

endmodule

### sim/tb_waveform_decimator.sv
`timescale 1ns / 100ps
// tb_waveform_decimator: stimulus and verdict for waveform_decimator
// drives config writes and sample records with random gaps and output stalls;
// depends on wd_pkg, the rtl and decimator_checker

module tb_waveform_decimator;
  import wd_pkg::*;

  localparam int LEN_W         = LENGTH_BITS_DEF;
  localparam int MAX_WAIT      = 17;
  localparam int RANDOM_ITEMS  = 1320;
  localparam int SETTLE_CYCLES = 40;     // half-average latency plus margin
  localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
  localparam int IDLE_LIMIT    = 2000;   // watchdog: cycles without any transfer
  localparam logic [LEN_W-1:0] LEN_MAX  = '1;
  localparam logic [LEN_W-1:0] LONG_LEN = LEN_W'(129);

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             cfg_we     = 1'b0;
  logic             cfg_addr   = CFG_MODE;
  logic [LEN_W-1:0] cfg_wdata  = '0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = '0;
  logic             in_tlast   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [15:0]      out_tdata;
  logic             out_tlast;

  int mismatches;
  int pairs_pending;
  int pairs_checked;

  // stimulus bookkeeping
  bit               no_gaps      = 1'b0;   // both sides stream without idling
  bit               hold_request = 1'b0;   // ask receiver for one long hold-off
  int               holds_done   = 0;
  int               samples_sent = 0;
  int               random_sent  = 0;
  int               phases       = 0;
  int               idle_cycles  = 0;
  logic [LEN_W-1:0] cur_len      = LEN_W'(1);   // group length as last written

  waveform_decimator #(.LENGTH_BITS(LEN_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [7:0] sample
    .in_tlast   (in_tlast),     // end of record
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [7:0] low_value, [15:8] high_value
    .out_tlast  (out_tlast)     // group closed at record end
  );

  decimator_checker #(.LEN_W(LEN_W)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .mismatches    (mismatches),
    .pairs_pending (pairs_pending),
    .pairs_checked (pairs_checked)
  );

  // 4 ns clock
  initial forever #2 clk = ~clk;

  function automatic int draw_wait();
    return no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // samples lean toward the rails so min/max and averages hit the extremes
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one sample transfer; valid stays high across back-to-back transfers
  task automatic send_sample(input logic [7:0] s, input logic eor);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= eor;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  // let every expected pair drain, then give the back end time to go quiet;
  // a partial group may stay in the front on purpose
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pairs_pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes only while idle; junk in the upper bits of the mode write
  task automatic write_settings(input bit wr_mode, input logic [MODE_W-1:0] m,
                                input bit wr_len, input logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] junk;
    junk = LEN_W'($urandom);
    if (wr_mode) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_MODE;
      cfg_wdata <= {junk[LEN_W-1:MODE_W], m};
      @(posedge clk);
    end
    if (wr_len) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_LENGTH;
      cfg_wdata <= l;
      cur_len    = l;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    phases++;
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return LEN_W'(1);
    if (r == 2) return LEN_MAX;
    if (r <= 12) return LEN_W'($urandom_range(2, 8));
    if (r <= 17) return LEN_W'($urandom_range(9, 40));
    return LEN_W'($urandom_range(41, 100));
  endfunction

  // one random phase: new settings, then mostly whole records with random content,
  // the rest broken records that end early
  task automatic random_phase();
    int n;
    int done;
    int groups;
    int rec_len;
    int eff;
    int i;
    bit close_rec;
    bit wr_mode;
    bit wr_len;
    settle();
    wr_mode = ($urandom_range(0, 3) != 0);
    wr_len  = ($urandom_range(0, 3) != 0);
    write_settings(wr_mode, MODE_W'($urandom_range(0, 3)), wr_len, pick_length());
    no_gaps = ($urandom_range(0, 4) == 0);
    n    = $urandom_range(20, 70);
    done = 0;
    eff  = (cur_len == 0) ? 1 : int'(cur_len);
    while (done < n) begin
      if ($urandom_range(0, 4) != 0 && eff <= 100) begin
        groups    = $urandom_range(1, 3);
        rec_len   = groups * eff;
        close_rec = ($urandom_range(0, 1) != 0);
        for (i = 0; i < rec_len; i++)
          send_sample(pick_sample(), close_rec && (i == rec_len - 1));
      end else begin
        rec_len = $urandom_range(1, 12);
        for (i = 0; i < rec_len; i++)
          send_sample(pick_sample(), (i == rec_len - 1) ? ($urandom_range(0, 1) != 0)
                                                        : ($urandom_range(0, 15) == 0));
      end
      done        += rec_len;
      random_sent += rec_len;
    end
    no_gaps = 1'b0;
  endtask

  // receiver: random stalls per pair, one long hold-off on request
  initial begin : receiver
    int stall;
    forever begin
      if (hold_request) begin
        out_tready  <= 1'b0;
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      stall = draw_wait();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // watchdog: any transfer or register write restarts the count
  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d pairs outstanding",
             IDLE_LIMIT, pairs_pending);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int i;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: plain, length 1, every sample is its own pair;
    // record end on the closing sample sets the last flag
    send_sample(8'h00, 1'b0);
    send_sample(8'hff, 1'b1);
    send_sample(8'h3c, 1'b0);

    // peak mode over a group of four, then a record end inside a group
    settle();
    write_settings(1'b1, MODE_PEAK, 1'b1, LEN_W'(4));
    send_sample(8'h80, 1'b0);
    send_sample(8'h00, 1'b0);
    send_sample(8'hff, 1'b0);
    send_sample(8'h01, 1'b0);
    send_sample(8'h10, 1'b0);
    send_sample(8'h20, 1'b0);
    send_sample(8'h30, 1'b1);

    // half averages with the larger half first, closed at a record end
    settle();
    write_settings(1'b1, MODE_HALF, 1'b0, '0);
    send_sample(8'hff, 1'b0);
    send_sample(8'hff, 1'b0);
    send_sample(8'h00, 1'b0);
    send_sample(8'h01, 1'b1);

    // unused mode code falls back to plain
    settle();
    write_settings(1'b1, MODE_SPARE, 1'b1, LEN_W'(3));
    send_sample(8'haa, 1'b0);
    send_sample(8'h55, 1'b0);
    send_sample(8'h00, 1'b0);

    // zero length acts as length one
    settle();
    write_settings(1'b1, MODE_PEAK, 1'b1, '0);
    send_sample(8'h5a, 1'b0);

    // shrink the length under a partly filled half-average group:
    // it closes on the next sample and both averages saturate
    settle();
    write_settings(1'b1, MODE_HALF, 1'b1, LEN_W'(8));
    for (i = 0; i < 6; i++) send_sample(8'hff, 1'b0);
    settle();
    write_settings(1'b0, MODE_PLAIN, 1'b1, LEN_W'(2));
    send_sample(8'hff, 1'b0);

    // pressure: receiver holds off while single-sample groups pour in
    settle();
    write_settings(1'b1, MODE_PLAIN, 1'b1, LEN_W'(1));
    no_gaps      = 1'b1;
    hold_request = 1'b1;
    for (i = 0; i < 40; i++) send_sample(pick_sample(), ($urandom_range(0, 1) != 0));
    no_gaps = 1'b0;

    // one long half-average group with uneven halves, streamed without gaps
    settle();
    write_settings(1'b1, MODE_HALF, 1'b1, LONG_LEN);
    no_gaps = 1'b1;
    for (i = 0; i < int'(LONG_LEN); i++)
      send_sample(pick_sample(), i == int'(LONG_LEN) - 1);
    no_gaps = 1'b0;

    // random phases
    while (random_sent < RANDOM_ITEMS) random_phase();

    settle();
    $display("run: %0d samples over %0d settings phases, %0d pairs checked",
             samples_sent, phases, pairs_checked);
    $display("run: all modes, lengths 0 to %0d, %0d long output hold-offs, %0d mismatches",
             LEN_MAX, holds_done, mismatches);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
